### hw/rtl/dsa_pkg.sv
// Shared types, widths and codes of the descriptor slot allocator.
package dsa_pkg;

  localparam int CAP_W      = 11;
  localparam int SIZE_W     = 13;
  localparam int ADDR_W     = 64;
  localparam int FIDX_W     = 32;
  localparam int OUT_IDX_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  // An offset at or above 2^OFF_W gives a quotient above any capacity.
  localparam int OFF_W      = CAP_W + SIZE_W;

  typedef enum logic [1:0] {
    CMD_ALLOC        = 2'd0,
    CMD_FREE_INDEX   = 2'd1,
    CMD_FREE_ADDRESS = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_CAPACITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

  localparam logic [CAP_W-1:0]  RST_SLOT_CAPACITY = 11'd1024;
  localparam logic [SIZE_W-1:0] RST_SLOT_SIZE     = 13'd32;

  typedef struct packed {
    logic              start;
    logic [OFF_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [OFF_W-1:0]  quotient;
    logic [SIZE_W-1:0] remainder;
  } div_rsp_t;

endpackage

### hw/rtl/dsa_stack.sv
// Free stack memory: one write port, one registered read port.
module dsa_stack #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/dsa_div.sv
// Restoring divider, one quotient bit per cycle.
module dsa_div (
  input  logic              clk,
  input  logic              rst,
  input  dsa_pkg::div_req_t req,
  output dsa_pkg::div_rsp_t rsp
);

  localparam int OW = dsa_pkg::OFF_W;
  localparam int SW = dsa_pkg::SIZE_W;
  localparam int NW = $clog2(OW + 1);

  logic          busy;
  logic          done;
  logic [NW-1:0] cnt;
  logic [OW-1:0] quo;
  logic [SW-1:0] rem;
  logic [SW-1:0] dvs;
  logic [SW:0]   rem_sh;
  logic [SW:0]   diff;
  logic          take;

  assign rem_sh = {rem, quo[OW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign take   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= NW'(OW);
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[OW-2:0], take};
      rem <= take ? diff[SW-1:0] : rem_sh[SW-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### hw/rtl/descriptor_slot_allocator.sv
// Descriptor slot allocator: bump counter with a LIFO free stack in memory.
//
// Channels: an input channel (command, free_index, free_address) and a result
// channel (status, slot_index, slot_cpu_address, slot_gpu_address), each with
// valid and stall; an item moves at an edge where valid is high and stall low.
// Every input item gives exactly one result item.
// Configuration: cfg_write_enable writes cfg_write_data into the register
// picked by cfg_index (capacity, slot size, CPU base, GPU base, shader visible).
// Write it only while the block is idle.
// Sequence: one item at a time. Stack allocate: decode, stack read, multiply,
// address add, result load; a bump allocate the same without stack read; a
// free by index: decode, push, result load; an exhausted allocate or an item
// refused at decode: decode, result load. A free by address that divides runs
// the divider, one quotient bit per cycle over 24 bits, then the push unless
// misaligned. The next item is accepted in the cycle after the result load.
// Reset: synchronous; free count and bump counter clear, the registers take
// their reset values, and the stack contents stay undefined until pushed.
// Stall: a finished result waits in the output register; the next item is
// accepted and processed meanwhile, and holds in its final state until the
// output register frees up.
module descriptor_slot_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsa_pkg::CFG_DATA_W-1:0]      cfg_write_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic [dsa_pkg::FIDX_W-1:0]          free_index,
  input  logic [dsa_pkg::ADDR_W-1:0]          free_address,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [dsa_pkg::OUT_IDX_W-1:0]       slot_index,
  output logic [dsa_pkg::ADDR_W-1:0]          slot_cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]          slot_gpu_address
);

  localparam int CAP_W     = dsa_pkg::CAP_W;
  localparam int SIZE_W    = dsa_pkg::SIZE_W;
  localparam int ADDR_W    = dsa_pkg::ADDR_W;
  localparam int FIDX_W    = dsa_pkg::FIDX_W;
  localparam int OFF_W     = dsa_pkg::OFF_W;
  localparam int OUT_IDX_W = dsa_pkg::OUT_IDX_W;
  // Largest capacity the register can express, then clamped to the heap.
  localparam int CAP_MAX   = (2 ** CAP_W) - 1;
  localparam int MAX_CLAMP = (MAX_SLOTS < CAP_MAX) ? MAX_SLOTS : CAP_MAX;
  localparam int IW        = (MAX_CLAMP > 1) ? $clog2(MAX_CLAMP) : 1;
  localparam int CW        = $clog2(MAX_SLOTS + 1);
  localparam int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int PW        = IW + SIZE_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_ADD    = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_PUSH   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  // Configuration registers
  logic [CAP_W-1:0]  slot_capacity;
  logic [SIZE_W-1:0] slot_size;
  logic [ADDR_W-1:0] cpu_base;
  logic [ADDR_W-1:0] gpu_base;
  logic              shader_visible;

  // Control state
  state_t            state;
  logic [CW-1:0]     free_count;
  logic [CAP_W-1:0]  bump_next;

  // Item payload and working registers
  dsa_pkg::command_t cmd_q;
  logic [FIDX_W-1:0] fidx_q;
  logic [ADDR_W-1:0] faddr_q;
  logic [FIDX_W-1:0] rel_idx;
  logic [IW-1:0]     idx;
  logic [PW-1:0]     prod;
  dsa_pkg::status_t  res_status;
  logic [IW-1:0]     res_idx;
  logic [ADDR_W-1:0] res_cpu;
  logic [ADDR_W-1:0] res_gpu;

  // Derived signals
  logic [CAP_W-1:0]  eff_cap;
  logic [ADDR_W:0]   off_full;
  logic              addr_below;
  logic              off_in_range;
  logic [CW-1:0]     fc_dec;
  logic              stack_full;
  logic              idx_bad;
  logic              out_free;
  logic [IW+OUT_IDX_W-1:0] idx_ext;

  // Stack port
  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  logic [IW-1:0]     stk_wdata;
  logic              stk_re;
  logic [AW-1:0]     stk_raddr;
  logic [IW-1:0]     stk_rdata;

  dsa_pkg::div_req_t div_req;
  dsa_pkg::div_rsp_t div_rsp;

  // Capacity saturates at the heap size.
  assign eff_cap = (slot_capacity > CAP_W'(MAX_CLAMP)) ? CAP_W'(MAX_CLAMP) : slot_capacity;

  // Address free: offset from the CPU base, borrow marks an address below it.
  assign off_full     = {1'b0, faddr_q} - {1'b0, cpu_base};
  assign addr_below   = off_full[ADDR_W];
  assign off_in_range = (off_full[ADDR_W-1:OFF_W] == '0);

  assign fc_dec     = free_count - CW'(1);
  assign stack_full = (free_count == CW'(MAX_SLOTS));
  assign idx_bad    = (rel_idx >= FIDX_W'(eff_cap));
  assign out_free   = !out_valid || !out_stall;
  assign idx_ext    = {{OUT_IDX_W{1'b0}}, res_idx};

  assign in_stall = (state != S_IDLE);

  // Pop: read the top entry while decoding an allocate.
  assign stk_re    = (state == S_DECODE) && (cmd_q == dsa_pkg::CMD_ALLOC) && (free_count != '0);
  assign stk_raddr = fc_dec[AW-1:0];
  // Push: write above the top once the index passes the checks.
  assign stk_we    = (state == S_PUSH) && !idx_bad && !stack_full;
  assign stk_waddr = free_count[AW-1:0];
  assign stk_wdata = rel_idx[IW-1:0];

  assign div_req.start    = (state == S_DECODE) && (cmd_q == dsa_pkg::CMD_FREE_ADDRESS) &&
                            !addr_below && (slot_size != '0) && off_in_range;
  assign div_req.dividend = off_full[OFF_W-1:0];
  assign div_req.divisor  = slot_size;

  dsa_stack #(
    .DEPTH (MAX_SLOTS),
    .AW    (AW),
    .DW    (IW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  dsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_capacity  <= dsa_pkg::RST_SLOT_CAPACITY;
      slot_size      <= dsa_pkg::RST_SLOT_SIZE;
      cpu_base       <= '0;
      gpu_base       <= '0;
      shader_visible <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        dsa_pkg::REG_SLOT_CAPACITY:  slot_capacity  <= cfg_write_data[CAP_W-1:0];
        dsa_pkg::REG_SLOT_SIZE:      slot_size      <= cfg_write_data[SIZE_W-1:0];
        dsa_pkg::REG_CPU_BASE:       cpu_base       <= cfg_write_data;
        dsa_pkg::REG_GPU_BASE:       gpu_base       <= cfg_write_data;
        dsa_pkg::REG_SHADER_VISIBLE: shader_visible <= cfg_write_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer, stack counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      bump_next  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (cmd_q)
            dsa_pkg::CMD_ALLOC: begin
              if (free_count != '0) begin
                free_count <= fc_dec;
                state      <= S_READ;
              end else if (bump_next >= eff_cap) begin
                state <= S_RESP;
              end else begin
                bump_next <= bump_next + CAP_W'(1);
                state     <= S_MUL;
              end
            end
            dsa_pkg::CMD_FREE_INDEX:   state <= S_PUSH;
            dsa_pkg::CMD_FREE_ADDRESS: state <= div_req.start ? S_DIV : S_RESP;
            default:                   state <= S_RESP;
          endcase
        end
        S_READ: state <= S_MUL;
        S_MUL:  state <= S_ADD;
        S_ADD:  state <= S_RESP;
        S_DIV: begin
          if (div_rsp.done) begin
            state <= (div_rsp.remainder == '0) ? S_PUSH : S_RESP;
          end
        end
        S_PUSH: begin
          if (stk_we) begin
            free_count <= free_count + CW'(1);
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload and result datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_q      <= dsa_pkg::command_t'(command);
          fidx_q     <= free_index;
          faddr_q    <= free_address;
          res_status <= dsa_pkg::ST_REJECTED;
          res_idx    <= '0;
          res_cpu    <= '0;
          res_gpu    <= '0;
        end
      end
      S_DECODE: begin
        rel_idx <= fidx_q;
        idx     <= bump_next[IW-1:0];
        if ((cmd_q == dsa_pkg::CMD_ALLOC) && (free_count == '0) && (bump_next >= eff_cap)) begin
          res_status <= dsa_pkg::ST_EXHAUSTED;
        end
      end
      S_READ: idx <= stk_rdata;
      S_MUL:  prod <= PW'(idx) * PW'(slot_size);
      S_ADD: begin
        res_status <= dsa_pkg::ST_OK;
        res_idx    <= idx;
        res_cpu    <= cpu_base + ADDR_W'(prod);
        res_gpu    <= shader_visible ? (gpu_base + ADDR_W'(prod)) : '0;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          rel_idx <= FIDX_W'(div_rsp.quotient);
        end
      end
      S_PUSH: begin
        // Bad index keeps the rejected status; a full stack drops the push.
        if (!idx_bad) begin
          res_status <= stack_full ? dsa_pkg::ST_FULL : dsa_pkg::ST_OK;
        end
      end
      S_RESP: begin
        if (out_free) begin
          status           <= res_status;
          slot_index       <= idx_ext[OUT_IDX_W-1:0];
          slot_cpu_address <= res_cpu;
          slot_gpu_address <= res_gpu;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // An accepted item always starts with a decode.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DECODE))
    else $error("accepted item did not enter decode");

  // A pop never reads an empty stack.
  assert property (@(posedge clk) disable iff (rst)
    stk_re |-> (free_count != '0))
    else $error("stack read with no entries");

  // A push never writes past the top of the memory.
  assert property (@(posedge clk) disable iff (rst)
    stk_we |-> (free_count < CW'(MAX_SLOTS)))
    else $error("stack write on a full stack");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider result outside the divide state");
`endif

endmodule

### bench/tb_top.sv
// Self-checking bench for the descriptor slot allocator: a directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;

  localparam int          MAX_SLOTS    = 1024;
  localparam int          PHASE_ITEMS  = 20;   // items in each ordinary random phase
  localparam int          HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int          IDLE_LIMIT   = 4000; // cycles with no item moving on either side
  localparam int          DRAIN_MARGIN = 8;    // settle time before a register write
  localparam int          REPORT_LIMIT = 60;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3; // the one command code with no meaning

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] fidx;
    logic [63:0] faddr;
  } slot_request_t;

  typedef struct packed {
    dsa_pkg::status_t status;
    logic [9:0]       index;
    logic [63:0]      cpu;
    logic [63:0]      gpu;
  } slot_result_t;

  typedef struct {
    bit            is_cfg;
    logic [2:0]    reg_idx;
    logic [63:0]   data;
    slot_request_t req;
    bit            typed;
    slot_result_t  exp;
  } stim_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Block ports
  logic        clk              = 1'b0;
  logic        rst              = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [2:0]  cfg_index        = '0;
  logic [63:0] cfg_write_data   = '0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [1:0]  command          = '0;
  logic [31:0] free_index       = '0;
  logic [63:0] free_address     = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [1:0]  status;
  logic [9:0]  slot_index;
  logic [63:0] slot_cpu_address;
  logic [63:0] slot_gpu_address;

  // Mirror of the configuration registers
  logic [10:0] cap_cfg;
  logic [12:0] size_cfg;
  logic [63:0] cpu_base_cfg;
  logic [63:0] gpu_base_cfg;
  logic        visible_cfg;

  // Mirror of the allocator state
  logic [9:0]  free_stack [MAX_SLOTS];
  int unsigned free_depth;
  int unsigned bump_next;

  slot_result_t awaited_slots [$];
  stim_row_t    opening_rows [$];
  int           mismatch_count  = 0;
  int           burst_left      = 0;
  int           hold_off_ask    = 0;
  int           hold_off_served = 0;

  descriptor_slot_allocator uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .free_index       (free_index),
    .free_address     (free_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .slot_index       (slot_index),
    .slot_cpu_address (slot_cpu_address),
    .slot_gpu_address (slot_gpu_address)
  );

  initial forever #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Capacity saturates at the depth of the heap.
  function automatic int unsigned eff_capacity();
    return (int'(cap_cfg) > MAX_SLOTS) ? MAX_SLOTS : int'(cap_cfg);
  endfunction

  function automatic logic [63:0] slot_address(logic [63:0] base, int unsigned k);
    return base + 64'(k) * 64'(size_cfg);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Push an index onto the free stack; out of range rejects, a full stack drops it.
  function automatic dsa_pkg::status_t push_free(logic [63:0] idx);
    if (idx >= 64'(eff_capacity())) return dsa_pkg::ST_REJECTED;
    if (free_depth >= MAX_SLOTS) return dsa_pkg::ST_FULL;
    free_stack[free_depth] = idx[9:0];
    free_depth++;
    return dsa_pkg::ST_OK;
  endfunction

  function automatic slot_result_t predict_slot(slot_request_t q);
    slot_result_t r;
    logic [63:0]  offset;
    logic [9:0]   granted_idx;
    bit           granted;
    r           = '0;
    r.status    = dsa_pkg::ST_REJECTED;
    granted     = 1'b0;
    granted_idx = '0;
    case (q.cmd)
      dsa_pkg::CMD_ALLOC: begin
        // Most recently freed index first, then the bump counter.
        if (free_depth > 0) begin
          free_depth--;
          granted_idx = free_stack[free_depth];
          granted     = 1'b1;
        end else if (bump_next >= eff_capacity()) begin
          r.status = dsa_pkg::ST_EXHAUSTED;
        end else begin
          granted_idx = 10'(bump_next);
          bump_next++;
          granted     = 1'b1;
        end
      end
      dsa_pkg::CMD_FREE_INDEX: r.status = push_free(64'(q.fidx));
      dsa_pkg::CMD_FREE_ADDRESS: begin
        // Below base, zero stride and misaligned offsets stay rejected.
        if (q.faddr >= cpu_base_cfg && size_cfg != 0) begin
          offset = q.faddr - cpu_base_cfg;
          if (offset % 64'(size_cfg) == 0) r.status = push_free(offset / 64'(size_cfg));
        end
      end
      default: ;
    endcase
    if (granted) begin
      r.status = dsa_pkg::ST_OK;
      r.index  = granted_idx;
      r.cpu    = slot_address(cpu_base_cfg, granted_idx);
      r.gpu    = visible_cfg ? slot_address(gpu_base_cfg, granted_idx) : 64'd0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random requests
  // ---------------------------------------------------------------------------

  // General mix: mostly well-formed frees and allocations, some noise.
  function automatic slot_request_t mixed_request();
    slot_request_t q;
    int unsigned   pick;
    int unsigned   lim;
    lim     = eff_capacity();
    pick    = $urandom_range(0, 99);
    q.cmd   = dsa_pkg::CMD_ALLOC;
    q.fidx  = $urandom;
    q.faddr = rand64();
    if (pick < 40) begin
      q.cmd = dsa_pkg::CMD_ALLOC;
    end else if (pick < 62) begin
      q.cmd = dsa_pkg::CMD_FREE_INDEX;
      case ($urandom_range(0, 9))
        0:       q.fidx = lim;      // first index past the end
        1:       ;                  // arbitrary 32-bit index
        default: q.fidx = (lim == 0) ? 32'd0 : $urandom_range(0, lim - 1);
      endcase
    end else if (pick < 94) begin
      q.cmd   = dsa_pkg::CMD_FREE_ADDRESS;
      q.faddr = slot_address(cpu_base_cfg, $urandom_range(0, lim + 1));
      case ($urandom_range(0, 9))
        0: if (size_cfg > 1) q.faddr += 64'($urandom_range(1, int'(size_cfg) - 1));
        1: if (cpu_base_cfg != 0) q.faddr = cpu_base_cfg - 64'(1 + $urandom_range(0, 1000));
        2: q.faddr = rand64();
        default: ;
      endcase
    end else begin
      q.cmd = CMD_UNUSED;
    end
    return q;
  endfunction

  // Fill mix: frees dominate so the stack climbs to its full depth.
  function automatic slot_request_t fill_request();
    slot_request_t q;
    int unsigned   pick;
    int unsigned   lim;
    lim     = (eff_capacity() == 0) ? 1 : eff_capacity();
    pick    = $urandom_range(0, 99);
    q.fidx  = $urandom;
    q.faddr = rand64();
    if (pick < 5) begin
      q.cmd = dsa_pkg::CMD_ALLOC;
    end else if (pick < 12) begin
      q.cmd   = dsa_pkg::CMD_FREE_ADDRESS;
      q.faddr = slot_address(cpu_base_cfg, $urandom_range(0, lim - 1));
    end else begin
      q.cmd  = dsa_pkg::CMD_FREE_INDEX;
      q.fidx = $urandom_range(0, lim - 1);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Lower valid and hold until every awaited result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_slots.size() != 0) @(posedge clk);
  endtask

  // Write one register once the block is idle; enable is lowered by whoever moves next.
  task automatic write_reg(logic [2:0] reg_idx, logic [63:0] data);
    drain_results();
    repeat (DRAIN_MARGIN) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= reg_idx;
    cfg_write_data   <= data;
    case (reg_idx)
      dsa_pkg::REG_SLOT_CAPACITY:  cap_cfg      = data[10:0];
      dsa_pkg::REG_SLOT_SIZE:      size_cfg     = data[12:0];
      dsa_pkg::REG_CPU_BASE:       cpu_base_cfg = data;
      dsa_pkg::REG_GPU_BASE:       gpu_base_cfg = data;
      dsa_pkg::REG_SHADER_VISIBLE: visible_cfg  = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [10:0] cap, logic [12:0] size, logic [63:0] cbase,
                            logic [63:0] gbase, logic visible);
    write_reg(dsa_pkg::REG_SLOT_CAPACITY, 64'(cap));
    write_reg(dsa_pkg::REG_SLOT_SIZE, 64'(size));
    write_reg(dsa_pkg::REG_CPU_BASE, cbase);
    write_reg(dsa_pkg::REG_GPU_BASE, gbase);
    write_reg(dsa_pkg::REG_SHADER_VISIBLE, 64'(visible));
  endtask

  // Offer one item in bursts with gaps; record its expectation at acceptance.
  task automatic send_item(slot_request_t q, bit typed = 1'b0, slot_result_t typed_exp = '0);
    slot_result_t pred;
    int           gap;
    cfg_write_enable <= 1'b0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      gap        = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid     <= 1'b1;
    command      <= q.cmd;
    free_index   <= q.fidx;
    free_address <= q.faddr;
    do @(posedge clk); while (in_stall);
    pred = predict_slot(q);
    if (typed) pred = typed_exp;
    awaited_slots.insert(awaited_slots.size(), pred);
  endtask

  // ---------------------------------------------------------------------------
  // Opening table
  // ---------------------------------------------------------------------------

  task automatic add_cfg(logic [2:0] reg_idx, logic [63:0] data);
    stim_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = reg_idx;
    row.data    = data;
    opening_rows.insert(opening_rows.size(), row);
  endtask

  task automatic add_item(logic [1:0] cmd, logic [31:0] fidx, logic [63:0] faddr);
    stim_row_t row;
    row     = '{default: '0};
    row.req = '{cmd: cmd, fidx: fidx, faddr: faddr};
    opening_rows.insert(opening_rows.size(), row);
  endtask

  task automatic add_typed(logic [1:0] cmd, logic [31:0] fidx, logic [63:0] faddr,
                           dsa_pkg::status_t st, logic [9:0] idx = '0,
                           logic [63:0] cpu = '0);
    stim_row_t row;
    row       = '{default: '0};
    row.req   = '{cmd: cmd, fidx: fidx, faddr: faddr};
    row.typed = 1'b1;
    row.exp   = '{status: st, index: idx, cpu: cpu, gpu: 64'd0};
    opening_rows.insert(opening_rows.size(), row);
  endtask

  task automatic build_opening();
    // Fresh heap: bump counter hands out 0 then 1.
    add_typed(dsa_pkg::CMD_ALLOC, '0, '0, dsa_pkg::ST_OK, 10'd0, 64'd0);
    add_typed(dsa_pkg::CMD_ALLOC, '0, '0, dsa_pkg::ST_OK, 10'd1, 64'd32);
    add_typed(dsa_pkg::CMD_FREE_INDEX, 32'd1, '0, dsa_pkg::ST_OK);
    add_item(dsa_pkg::CMD_ALLOC, '0, '0);                            // pops the freed index
    add_typed(dsa_pkg::CMD_FREE_INDEX, 32'd1024, '0, dsa_pkg::ST_REJECTED); // out of range
    add_typed(dsa_pkg::CMD_FREE_INDEX, '1, '0, dsa_pkg::ST_REJECTED);
    add_typed(dsa_pkg::CMD_FREE_ADDRESS, '0, 64'd33, dsa_pkg::ST_REJECTED);  // misaligned
    add_item(dsa_pkg::CMD_FREE_ADDRESS, '0, 64'd64);
    // Quotient past capacity.
    add_typed(dsa_pkg::CMD_FREE_ADDRESS, '0, 64'd32768, dsa_pkg::ST_REJECTED);
    add_typed(CMD_UNUSED, '1, '1, dsa_pkg::ST_REJECTED);
    // Base near the top so granted addresses wrap; GPU addresses on.
    add_cfg(dsa_pkg::REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
    add_cfg(dsa_pkg::REG_GPU_BASE, 64'h0000_1000_0000_0000);
    add_cfg(dsa_pkg::REG_SHADER_VISIBLE, 64'd1);
    add_typed(dsa_pkg::CMD_FREE_ADDRESS, '0, 64'd0, dsa_pkg::ST_REJECTED);   // below base
    add_typed(dsa_pkg::CMD_FREE_ADDRESS, '0, '1, dsa_pkg::ST_REJECTED);      // offset 15
    add_item(dsa_pkg::CMD_ALLOC, '0, '0);
    add_item(dsa_pkg::CMD_ALLOC, '0, '0);
    // Zero stride: every address free is refused.
    add_cfg(dsa_pkg::REG_SLOT_SIZE, 64'd0);
    add_typed(dsa_pkg::CMD_FREE_ADDRESS, '0, 64'hFFFF_FFFF_FFFF_FFF0, dsa_pkg::ST_REJECTED);
    add_item(dsa_pkg::CMD_ALLOC, '0, '0);
    // Stride of 4096, capacity above the heap depth saturates.
    add_cfg(dsa_pkg::REG_SLOT_SIZE, 64'd4096);
    add_cfg(dsa_pkg::REG_SLOT_CAPACITY, 64'd2047);
    add_typed(dsa_pkg::CMD_FREE_INDEX, 32'd1023, '0, dsa_pkg::ST_OK);
    add_typed(dsa_pkg::CMD_FREE_INDEX, 32'd1024, '0, dsa_pkg::ST_REJECTED);
    add_item(dsa_pkg::CMD_ALLOC, '0, '0);
    // Capacity zero: nothing left to hand out.
    add_cfg(dsa_pkg::REG_SLOT_CAPACITY, 64'd0);
    add_typed(dsa_pkg::CMD_ALLOC, '0, '0, dsa_pkg::ST_EXHAUSTED);
    add_typed(dsa_pkg::CMD_FREE_INDEX, 32'd0, '0, dsa_pkg::ST_REJECTED);
    // Capacity under the bump counter: stacked indices still come out.
    add_cfg(dsa_pkg::REG_SLOT_CAPACITY, 64'd2);
    add_typed(dsa_pkg::CMD_FREE_INDEX, 32'd1, '0, dsa_pkg::ST_OK);
    add_item(dsa_pkg::CMD_ALLOC, '0, '0);
    add_typed(dsa_pkg::CMD_ALLOC, '0, '0, dsa_pkg::ST_EXHAUSTED);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Reset values of the registers and an empty heap.
    cap_cfg      = dsa_pkg::RST_SLOT_CAPACITY;
    size_cfg     = dsa_pkg::RST_SLOT_SIZE;
    cpu_base_cfg = '0;
    gpu_base_cfg = '0;
    visible_cfg  = 1'b0;
    free_depth   = 0;
    bump_next    = 0;
    foreach (free_stack[i]) free_stack[i] = '0;
    build_opening();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].is_cfg)
        write_reg(opening_rows[i].reg_idx, opening_rows[i].data);
      else
        send_item(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].exp);
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(11'd8, 13'd1, 64'd0, '1, 1'b1);
        1: set_config(11'd1024, 13'd4096, 64'hFFFF_FFFF_FFF0_0000, rand64(), 1'b1);
        2: set_config(11'd2047, 13'd24, rand64() >> 1, rand64(), 1'($urandom));
        3: set_config(11'd0, 13'd0, rand64(), rand64(), 1'b0);
        4: set_config(11'($urandom_range(1, 64)), 13'($urandom_range(1, 4096)),
                      rand64(), rand64(), 1'b1);
        default: set_config(11'($urandom_range(0, 2047)), 13'($urandom_range(0, 4096)),
                            rand64(), rand64(), 1'($urandom));
      endcase
      if (p == 1) hold_off_ask++;   // receiver holds off while items keep coming
      if (p == 2) begin
        // Fill the stack to its full depth, then push past it.
        while (free_depth < MAX_SLOTS) send_item(fill_request());
        repeat (12) send_item(fill_request());
        repeat (20) send_item(mixed_request());
      end else begin
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
          send_item(mixed_request());
        end
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       period;
    int       tick;
    mode      = RX_FREE;
    mode_left = 0;
    period    = 2;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
        period    = $urandom_range(2, 9);
      end
      mode_left--;
      tick++;
      if (hold_off_ask != hold_off_served) begin
        hold_off_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_stall <= (tick % period == 0);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  initial begin
    slot_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (awaited_slots.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with nothing awaited, expected none, actual status %h",
                     $time, status);
        end else begin
          want = awaited_slots.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("slot_index", 64'(want.index), 64'(slot_index));
          check_field("slot_cpu_address", want.cpu, slot_cpu_address);
          check_field("slot_gpu_address", want.gpu, slot_gpu_address);
        end
      end
    end
  end

  // Watchdog: end the run when no item moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

endmodule

### sim.f
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_stack.sv
hw/rtl/dsa_div.sv
hw/rtl/descriptor_slot_allocator.sv
bench/tb_top.sv
